// ===== sv/dpt_pkg.sv =====
// Package for the digest pin table: codes, widths, hardwired static pins and
// the static pin lookup. No dependencies.
package dpt_pkg;

  localparam int PinSlotsDef = 32;
  localparam int DigestW     = 256;
  localparam int StaticPinN  = 3;

  typedef enum logic [1:0] {
    ACT_CERT  = 2'd0,
    ACT_ROOT  = 2'd1,
    ACT_ABORT = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    MODE_OFF    = 2'd0,
    MODE_WARN   = 2'd1,
    MODE_STRICT = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    KIND_NONE    = 2'd0,
    KIND_STATIC  = 2'd1,
    KIND_DYNAMIC = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_EVAL,
    ST_LEAF_LOOK,
    ST_LEAF_EVAL,
    ST_DONE
  } state_e;

  localparam logic [1:0] StaticNone = 2'd3;

  // digest word 0 in the top bits
  localparam logic [DigestW-1:0] StaticPins [StaticPinN] = '{
    256'hb0db909ebee1ecc1_717bee9a8a302bd7_8383ce2c1a5ef2c9_14e7ad49e5163621,
    256'h1dfc1605fbad358d_8bc844f76d15203f_ac9ca5c1a79fd485_7ffaf2864fbebf96,
    256'h76b27b80a58027dc_3cf1da68dac17010_ed93997d0b603e2f_adbe85012493b5a7
  };

  // first matching static pin, StaticNone if none
  function automatic logic [1:0] static_lookup(input logic [DigestW-1:0] dg);
    logic [1:0] idx;
    idx = StaticNone;
    for (int i = StaticPinN - 1; i >= 0; i--) begin
      if (dg == StaticPins[i]) begin
        idx = 2'(i);
      end
    end
    return idx;
  endfunction

endpackage

// ===== sv/dpt_cell.sv =====
// One slot of the dynamic pin store: holds a digest, compares it with the
// broadcast key and ORs its registered hit into the chain. Uses dpt_pkg.
module dpt_cell #(
  parameter int PIN_SLOTS = dpt_pkg::PinSlotsDef,
  parameter int SLOT_IDX  = 0,
  localparam int SlotW = (PIN_SLOTS > 1) ? $clog2(PIN_SLOTS) : 1,
  localparam int CntW  = $clog2(PIN_SLOTS + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [dpt_pkg::DigestW-1:0] key_i,
  input  logic                        wr_en_i,
  input  logic [SlotW-1:0]            wr_slot_i,
  input  logic [CntW-1:0]             count_i,
  input  logic                        hit_i,
  output logic                        hit_o
);
  import dpt_pkg::*;

  logic [DigestW-1:0] data_q;
  logic               hit_q, hit_d;
  logic               live;

  assign live  = count_i > CntW'(SLOT_IDX);
  assign hit_d = live && (data_q == key_i);

  always_ff @(posedge clk_i) begin
    if (wr_en_i && (wr_slot_i == SlotW'(SLOT_IDX))) begin
      data_q <= key_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else begin
      hit_q <= hit_d;
    end
  end

  assign hit_o = hit_i | hit_q;

endmodule

// ===== sv/dpt_cell_row.sv =====
// Row of PIN_SLOTS store cells; the hit flag ripples from cell 0 to the end.
// Uses dpt_pkg and dpt_cell.
module dpt_cell_row #(
  parameter int PIN_SLOTS = dpt_pkg::PinSlotsDef,
  localparam int SlotW = (PIN_SLOTS > 1) ? $clog2(PIN_SLOTS) : 1,
  localparam int CntW  = $clog2(PIN_SLOTS + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [dpt_pkg::DigestW-1:0] key_i,
  input  logic                        wr_en_i,
  input  logic [SlotW-1:0]            wr_slot_i,
  input  logic [CntW-1:0]             count_i,
  output logic                        any_hit_o
);
  import dpt_pkg::*;

  logic [PIN_SLOTS:0] hit_chain;

  assign hit_chain[0] = 1'b0;

  for (genvar k = 0; k < PIN_SLOTS; k++) begin : g_cell
    dpt_cell #(
      .PIN_SLOTS(PIN_SLOTS),
      .SLOT_IDX (k)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .key_i    (key_i),
      .wr_en_i  (wr_en_i),
      .wr_slot_i(wr_slot_i),
      .count_i  (count_i),
      .hit_i    (hit_chain[k]),
      .hit_o    (hit_chain[k+1])
    );
  end

  assign any_hit_o = hit_chain[PIN_SLOTS];

endmodule

// ===== sv/digest_pin_table_fifo.sv =====
// Top level of the digest pin table: sequencer, chain state, static pin check
// and output register. Uses dpt_pkg and dpt_cell_row.
//
//  channel   | signals                          | payload
//  ----------+----------------------------------+---------------------------------
//  s_axis    | tvalid tready tdata tuser tlast  | tdata: digest_w0..w3; tuser:
//            |                                  | action, first_cert; tlast: last
//  m_axis    | tvalid tready tdata tuser        | tdata: accept, static_index,
//            |                                  | leaf_captured, root_added, pins_held
//  cfg       | cfg_valid_i cfg_ready_o          | cfg_wdata_i: pin_mode
//
// A chain item without a result is loaded, compared in the cell row (ST_LOOK) and
// evaluated (ST_EVAL); items with a result then pass ST_DONE to the output register,
// and a static match with a leaf first passes the leaf through the cell row again.
// The cell hit flags are registered, so each store lookup has its own compare state.
// Reset clears the chain flags, the store count and the FIFO pointer; no
// clearing pass. A stalled m_axis holds the sequencer in its final state.
module digest_pin_table_fifo #(
  parameter int PIN_SLOTS = dpt_pkg::PinSlotsDef,
  localparam int SlotW = (PIN_SLOTS > 1) ? $clog2(PIN_SLOTS) : 1,
  localparam int CntW  = $clog2(PIN_SLOTS + 1)
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [255:0] s_axis_tdata,   // digest_w0, digest_w1, digest_w2, digest_w3
  input  logic [2:0]   s_axis_tuser,   // action[1:0], first_cert
  input  logic         s_axis_tlast,   // last_cert
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [15:0]  m_axis_tdata,   // accept, static_index[1:0], leaf_captured,
                                       // root_added, pins_held[5:0], zero pad
  output logic [1:0]   m_axis_tuser,   // match_kind
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_wdata_i
);
  import dpt_pkg::*;

  state_e state_q, state_d;

  logic [1:0]         mode_q;
  logic [DigestW-1:0] key_q, key_d;
  logic [DigestW-1:0] leaf_q, leaf_d;
  action_e            act_q;
  logic               first_q, last_q;

  logic               leaf_vld_q, leaf_vld_d;
  logic               matched_q, matched_d;
  logic               dynamic_q, dynamic_d;
  logic [1:0]         sslot_q, sslot_d;

  logic [CntW-1:0]    count_q, count_d;
  logic [SlotW-1:0]   oldest_q, oldest_d;
  logic               put;
  logic [SlotW-1:0]   put_slot;

  logic               res_acc_q, res_acc_d;
  kind_e              res_kind_q, res_kind_d;
  logic [1:0]         res_sidx_q, res_sidx_d;
  logic               res_cap_q, res_cap_d;
  logic               res_radd_q, res_radd_d;

  logic               m_vld_q, m_vld_d;
  logic [15:0]        m_data_q, m_data_d;
  kind_e              m_kind_q, m_kind_d;

  logic               any_hit;
  logic               in_fire, out_free, done_fire;
  logic               chain_on, strict;
  logic               m_now, dyn_now, lv_now;
  logic [1:0]         sidx_now, shit;
  logic [DigestW-1:0] leaf_now;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_vld_q || m_axis_tready;
  assign done_fire     = (state_q == ST_DONE) && out_free;
  assign cfg_ready_o   = 1'b1;
  assign chain_on      = (mode_q != MODE_OFF);
  assign strict        = (mode_q == MODE_STRICT);

  dpt_cell_row #(
    .PIN_SLOTS(PIN_SLOTS)
  ) u_row (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .key_i    (key_q),
    .wr_en_i  (put),
    .wr_slot_i(put_slot),
    .count_i  (count_q),
    .any_hit_o(any_hit)
  );

  // chain flags as seen by this item after leaf restart and lookup
  always_comb begin
    shit     = static_lookup(key_q);
    m_now    = first_q ? 1'b0 : matched_q;
    dyn_now  = first_q ? 1'b0 : dynamic_q;
    sidx_now = first_q ? StaticNone : sslot_q;
    lv_now   = first_q | leaf_vld_q;
    leaf_now = first_q ? key_q : leaf_q;
    if (!m_now) begin
      if (shit != StaticNone) begin
        m_now    = 1'b1;
        sidx_now = shit;
      end else if (any_hit) begin
        m_now   = 1'b1;
        dyn_now = 1'b1;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire && (action_e'(s_axis_tuser[1:0]) != ACT_NONE)) begin
          state_d = ST_LOOK;
        end
      end
      ST_LOOK: state_d = ST_EVAL;
      ST_EVAL: begin
        state_d = ST_DONE;
        if (act_q == ACT_CERT) begin
          if (!last_q) begin
            state_d = ST_IDLE;
          end else if (chain_on && m_now && !dyn_now && lv_now) begin
            state_d = ST_LEAF_LOOK;
          end
        end
      end
      ST_LEAF_LOOK: state_d = ST_LEAF_EVAL;
      ST_LEAF_EVAL: state_d = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    key_d      = key_q;
    leaf_d     = leaf_q;
    leaf_vld_d = leaf_vld_q;
    matched_d  = matched_q;
    dynamic_d  = dynamic_q;
    sslot_d    = sslot_q;
    res_acc_d  = res_acc_q;
    res_kind_d = res_kind_q;
    res_sidx_d = res_sidx_q;
    res_cap_d  = res_cap_q;
    res_radd_d = res_radd_q;
    put        = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          key_d = {s_axis_tdata[63:0], s_axis_tdata[127:64],
                   s_axis_tdata[191:128], s_axis_tdata[255:192]};
        end
      end
      ST_EVAL: begin
        res_acc_d  = 1'b1;
        res_kind_d = KIND_NONE;
        res_sidx_d = StaticNone;
        res_cap_d  = 1'b0;
        res_radd_d = 1'b0;
        case (act_q)
          ACT_ROOT: begin
            if (!any_hit) begin
              put        = 1'b1;
              res_radd_d = 1'b1;
            end
          end
          ACT_ABORT: begin
            res_acc_d  = !strict;
            leaf_vld_d = 1'b0;
            matched_d  = 1'b0;
            dynamic_d  = 1'b0;
            sslot_d    = StaticNone;
          end
          ACT_CERT: begin
            if (chain_on) begin
              leaf_vld_d = lv_now;
              leaf_d     = leaf_now;
              matched_d  = m_now;
              dynamic_d  = dyn_now;
              sslot_d    = sidx_now;
              if (m_now) begin
                res_kind_d = dyn_now ? KIND_DYNAMIC : KIND_STATIC;
                res_sidx_d = dyn_now ? StaticNone : sidx_now;
              end else begin
                res_acc_d = !strict;
              end
            end
            if (last_q) begin
              key_d      = leaf_now;
              leaf_vld_d = 1'b0;
              matched_d  = 1'b0;
              dynamic_d  = 1'b0;
              sslot_d    = StaticNone;
            end
          end
          default: ;
        endcase
      end
      ST_LEAF_EVAL: begin
        if (!any_hit) begin
          put       = 1'b1;
          res_cap_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    count_d  = count_q;
    oldest_d = oldest_q;
    put_slot = oldest_q;
    if (count_q < CntW'(PIN_SLOTS)) begin
      put_slot = count_q[SlotW-1:0];
      if (put) begin
        count_d = count_q + 1'b1;
      end
    end else if (put) begin
      oldest_d = (oldest_q == SlotW'(PIN_SLOTS - 1)) ? '0 : oldest_q + 1'b1;
    end
  end

  always_comb begin
    m_vld_d  = m_vld_q && !m_axis_tready;
    m_data_d = m_data_q;
    m_kind_d = m_kind_q;
    if (done_fire) begin
      m_vld_d  = 1'b1;
      m_data_d = {5'd0, 6'(count_q), res_radd_q, res_cap_q, res_sidx_q, res_acc_q};
      m_kind_d = res_kind_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      mode_q     <= MODE_WARN;
      leaf_vld_q <= 1'b0;
      matched_q  <= 1'b0;
      dynamic_q  <= 1'b0;
      sslot_q    <= StaticNone;
      count_q    <= '0;
      oldest_q   <= '0;
      m_vld_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      leaf_vld_q <= leaf_vld_d;
      matched_q  <= matched_d;
      dynamic_q  <= dynamic_d;
      sslot_q    <= sslot_d;
      count_q    <= count_d;
      oldest_q   <= oldest_d;
      m_vld_q    <= m_vld_d;
      if (cfg_valid_i) begin
        mode_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_q      <= key_d;
    leaf_q     <= leaf_d;
    res_acc_q  <= res_acc_d;
    res_kind_q <= res_kind_d;
    res_sidx_q <= res_sidx_d;
    res_cap_q  <= res_cap_d;
    res_radd_q <= res_radd_d;
    m_data_q   <= m_data_d;
    m_kind_q   <= m_kind_d;
    if (in_fire) begin
      act_q   <= action_e'(s_axis_tuser[1:0]);
      first_q <= s_axis_tuser[2];
      last_q  <= s_axis_tlast;
    end
  end

  assign m_axis_tvalid = m_vld_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_kind_q;

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(PIN_SLOTS))
    else $error("store count above slot count");

  a_oldest_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (oldest_q != '0) |-> (count_q == CntW'(PIN_SLOTS)))
    else $error("eviction pointer moved before store filled");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == $past(count_q)) || (count_q == $past(count_q) + 1'b1))
    else $error("store count changed by more than one");

  a_put_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    put |-> ((state_q == ST_EVAL) && (act_q == ACT_ROOT)) || (state_q == ST_LEAF_EVAL))
    else $error("store write outside a lookup result");

  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == ST_DONE))
    else $error("result raised outside the done state");

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking bench for digest_pin_table_fifo: directed chains, then random
// chains, root adds and aborts under every pin mode and four idle/stall patterns.
// Depends on dpt_pkg and the RTL of the block.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dpt_pkg::*;

  localparam int PinSlots = 32;
  localparam int SettleCycles = 12;
  localparam int PoolN = 40;
  localparam int MaxPrints = 50;
  localparam logic [1:0] ModeReserved = 2'd3;

  // {w3, w2, w1, w0}, same layout as s_axis_tdata
  localparam logic [255:0] StaticDigest [3] = '{
    {64'h14e7ad49e5163621, 64'h8383ce2c1a5ef2c9, 64'h717bee9a8a302bd7, 64'hb0db909ebee1ecc1},
    {64'h7ffaf2864fbebf96, 64'hac9ca5c1a79fd485, 64'h8bc844f76d15203f, 64'h1dfc1605fbad358d},
    {64'hadbe85012493b5a7, 64'hed93997d0b603e2f, 64'h3cf1da68dac17010, 64'h76b27b80a58027dc}
  };

  typedef struct packed {
    logic       accept;
    logic [1:0] kind;
    logic [1:0] sidx;
    logic       cap;
    logic       radd;
    logic [5:0] held;
  } verdict_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [255:0] s_axis_tdata = '0;
  logic [2:0]   s_axis_tuser = '0;
  logic         s_axis_tlast = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [15:0]  m_axis_tdata;
  logic [1:0]   m_axis_tuser;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [1:0]   cfg_wdata_i = '0;

  int idle_pct = 0;
  int stall_pct = 0;
  int err_count = 0;
  int result_n = 0;

  verdict_t verdict_q [$];

  // predicted block state
  logic [1:0]   mode_q = MODE_WARN;
  logic [255:0] pin_slot_q [PinSlots];
  int unsigned  held_n = 0;
  int unsigned  evict_ptr = 0;
  logic [255:0] leaf_dg = '0;
  bit           leaf_ok = 1'b0;
  bit           chain_hit = 1'b0;
  bit           chain_dyn = 1'b0;
  logic [1:0]   chain_sidx = StaticNone;

  logic [255:0] dg_pool [PoolN];

  digest_pin_table_fifo u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("Some tests failed");
    $finish;
  end

  function automatic logic [255:0] rand_digest();
    return {$urandom, $urandom, $urandom, $urandom,
            $urandom, $urandom, $urandom, $urandom};
  endfunction

  function automatic bit store_has(logic [255:0] dg);
    for (int i = 0; i < held_n; i++) begin
      if (pin_slot_q[i] == dg) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void store_push(logic [255:0] dg);
    if (held_n < PinSlots) begin
      pin_slot_q[held_n] = dg;
      held_n++;
    end else begin
      pin_slot_q[evict_ptr] = dg;
      evict_ptr = (evict_ptr + 1) % PinSlots;
    end
  endfunction

  function automatic void chain_reset();
    leaf_ok = 1'b0;
    chain_hit = 1'b0;
    chain_dyn = 1'b0;
    chain_sidx = StaticNone;
  endfunction

  // advances the predicted state by one transaction; returns 1 if it yields a result
  function automatic bit pin_table_eval(action_e act, logic [255:0] dg, bit first, bit last,
                                        output verdict_t v);
    v.accept = 1'b1;
    v.kind = KIND_NONE;
    v.sidx = StaticNone;
    v.cap = 1'b0;
    v.radd = 1'b0;
    v.held = '0;
    case (act)
      ACT_NONE: return 1'b0;
      ACT_ROOT: begin
        if (!store_has(dg)) begin
          store_push(dg);
          v.radd = 1'b1;
        end
      end
      ACT_ABORT: begin
        v.accept = (mode_q != MODE_STRICT);
        chain_reset();
      end
      default: begin
        if (mode_q != MODE_OFF) begin
          if (first) begin
            chain_reset();
            leaf_dg = dg;
            leaf_ok = 1'b1;
          end
          if (!chain_hit) begin
            for (int i = 0; i < 3; i++) begin
              if (!chain_hit && dg == StaticDigest[i]) begin
                chain_hit = 1'b1;
                chain_sidx = 2'(i);
              end
            end
            if (!chain_hit && store_has(dg)) begin
              chain_hit = 1'b1;
              chain_dyn = 1'b1;
            end
          end
        end
        if (!last) return 1'b0;
        if (mode_q != MODE_OFF) begin
          if (chain_hit && chain_dyn) begin
            v.kind = KIND_DYNAMIC;
          end else if (chain_hit) begin
            v.kind = KIND_STATIC;
            v.sidx = chain_sidx;
            if (leaf_ok && !store_has(leaf_dg)) begin
              store_push(leaf_dg);
              v.cap = 1'b1;
            end
          end else begin
            v.accept = (mode_q != MODE_STRICT);
          end
        end
        chain_reset();
      end
    endcase
    v.held = 6'(held_n);
    return 1'b1;
  endfunction

  function automatic logic [255:0] next_digest();
    int sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0, 1: return StaticDigest[$urandom_range(0, 2)];
      2: return StaticDigest[$urandom_range(0, 2)] ^ (256'd1 << $urandom_range(0, 255));
      3, 4, 5: return dg_pool[$urandom_range(0, PoolN - 1)];
      6: return $urandom_range(0, 1) ? '1 : '0;
      7: begin
        dg_pool[$urandom_range(0, PoolN - 1)] = rand_digest();
        return rand_digest();
      end
      default: return rand_digest();
    endcase
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    if (err_count < MaxPrints) begin
      $display("MISMATCH result %0d %s: got %0d expected %0d", result_n, field, got, want);
    end
    err_count++;
  endtask

  // result checker and receiver stall generator
  always @(posedge clk_i) begin
    verdict_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (verdict_q.size() == 0) begin
        report_mismatch("unexpected transaction", int'(m_axis_tdata), 0);
      end else begin
        want = verdict_q.pop_front();
        if (m_axis_tdata[0] !== want.accept)
          report_mismatch("accept", int'(m_axis_tdata[0]), int'(want.accept));
        if (m_axis_tuser !== want.kind)
          report_mismatch("match_kind", int'(m_axis_tuser), int'(want.kind));
        if (m_axis_tdata[2:1] !== want.sidx)
          report_mismatch("static_index", int'(m_axis_tdata[2:1]), int'(want.sidx));
        if (m_axis_tdata[3] !== want.cap)
          report_mismatch("leaf_captured", int'(m_axis_tdata[3]), int'(want.cap));
        if (m_axis_tdata[4] !== want.radd)
          report_mismatch("root_added", int'(m_axis_tdata[4]), int'(want.radd));
        if (m_axis_tdata[10:5] !== want.held)
          report_mismatch("pins_held", int'(m_axis_tdata[10:5]), int'(want.held));
      end
      result_n++;
    end
    m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  task automatic send_item(action_e act, logic [255:0] dg, bit first, bit last);
    verdict_t v;
    while ($urandom_range(0, 99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= dg;
    s_axis_tuser <= {first, act};
    s_axis_tlast <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (pin_table_eval(act, dg, first, last, v)) verdict_q.push_back(v);
  endtask

  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_mode(logic [1:0] m);
    wait_drain();
    cfg_valid_i <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    mode_q = m;
  endtask

  task automatic test_static_match(logic [255:0] leaf);
    send_item(ACT_CERT, leaf, 1'b1, 1'b0);
    send_item(ACT_CERT, StaticDigest[0], 1'b0, 1'b1);
    send_item(ACT_CERT, StaticDigest[2], 1'b1, 1'b1);
    send_item(ACT_CERT, leaf, 1'b1, 1'b0);
    send_item(ACT_CERT, StaticDigest[1], 1'b0, 1'b1);
    // no leaf in this chain: match but nothing to capture
    send_item(ACT_CERT, StaticDigest[1], 1'b0, 1'b1);
    send_item(ACT_CERT, StaticDigest[0] ^ 256'd1, 1'b1, 1'b1);
  endtask

  task automatic test_dynamic_and_root(logic [255:0] leaf);
    send_item(ACT_CERT, leaf, 1'b1, 1'b1);
    send_item(ACT_ROOT, '1, 1'b0, 1'b0);
    send_item(ACT_ROOT, '1, 1'b1, 1'b1);
    send_item(ACT_CERT, '0, 1'b1, 1'b0);
    send_item(ACT_CERT, '1, 1'b0, 1'b1);
    send_item(ACT_NONE, '1, 1'b1, 1'b1);
  endtask

  task automatic test_chain_cases();
    // second leaf restarts the chain and drops the static hit
    send_item(ACT_CERT, StaticDigest[0], 1'b1, 1'b0);
    send_item(ACT_CERT, rand_digest(), 1'b1, 1'b0);
    send_item(ACT_CERT, rand_digest(), 1'b0, 1'b1);
    send_item(ACT_CERT, StaticDigest[0], 1'b1, 1'b0);
    send_item(ACT_ABORT, rand_digest(), 1'b0, 1'b0);
  endtask

  task automatic test_modes();
    write_mode(MODE_STRICT);
    send_item(ACT_CERT, rand_digest(), 1'b1, 1'b1);
    send_item(ACT_ABORT, '0, 1'b1, 1'b1);
    send_item(ACT_CERT, StaticDigest[1], 1'b1, 1'b1);
    write_mode(MODE_OFF);
    send_item(ACT_CERT, StaticDigest[0], 1'b1, 1'b1);
    send_item(ACT_ROOT, rand_digest(), 1'b0, 1'b0);
    write_mode(ModeReserved);
    send_item(ACT_CERT, rand_digest(), 1'b1, 1'b1);
  endtask

  task automatic test_random(int idle, int stall, logic [1:0] mode, int n_items);
    int sent;
    int pick;
    int len;
    write_mode(mode);
    idle_pct = idle;
    stall_pct = stall;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        len = $urandom_range(1, 4);
        for (int k = 0; k < len; k++) begin
          if (k == len - 1 && $urandom_range(0, 9) == 0) begin
            send_item(ACT_ABORT, next_digest(), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
          end else begin
            send_item(ACT_CERT, next_digest(),
                      (k == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 19) == 0),
                      k == len - 1);
          end
        end
        sent += len;
      end else if (pick < 82) begin
        send_item(ACT_ROOT, next_digest(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        sent++;
      end else if (pick < 88) begin
        send_item(ACT_ABORT, next_digest(), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
        sent++;
      end else if (pick < 92) begin
        send_item(ACT_NONE, rand_digest(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end else begin
        send_item(ACT_CERT, next_digest(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        sent++;
      end
      if ($urandom_range(0, 199) == 0) wait_drain();
    end
  endtask

  initial begin
    logic [255:0] leaf;
    for (int i = 0; i < PoolN; i++) dg_pool[i] = rand_digest();
    leaf = rand_digest();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_static_match(leaf);
    test_dynamic_and_root(leaf);
    test_chain_cases();
    test_modes();
    test_random(0, 0, MODE_WARN, 170);
    test_random(0, 0, MODE_STRICT, 170);
    test_random(64, 0, MODE_STRICT, 170);
    test_random(64, 0, MODE_OFF, 160);
    test_random(0, 64, MODE_WARN, 170);
    test_random(0, 64, ModeReserved, 160);
    test_random(27, 27, MODE_STRICT, 170);
    test_random(27, 27, MODE_WARN, 170);
    wait_drain();
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
